// File: hdl/swds_pkg.sv
// ---------------------------------------------------------------------------
// swds_pkg - shared types and constants of the stepper wave-drive sequencer
// Command and result words, register indexes, status codes, the
// constant-divider setup for the angle conversion and the coil pattern
// function.
// ---------------------------------------------------------------------------
package swds_pkg;

    localparam int MOTOR_COUNT     = 4;
    localparam int DEGREES_PER_REV = 360;

    localparam logic [2:0] MOTOR_LIMIT = 3'(MOTOR_COUNT);

    localparam logic [12:0] STEPS_REV_RESET = 13'd200;
    localparam logic [12:0] STEPS_REV_MAX   = 13'd4096;

    // Divide by 360 as a shift by 3 then a reciprocal multiply for 45.
    // Exact for every product below 2^20.
    localparam int DIV_PRE_SHIFT = 3;
    localparam int DIV_ODD       = DEGREES_PER_REV / (1 << DIV_PRE_SHIFT);
    localparam int DIV_SHIFT     = 23;
    localparam int DIV_RECIP     = ((1 << DIV_SHIFT) + DIV_ODD - 1) / DIV_ODD;

    typedef enum logic [1:0] {
        KIND_ROTATE = 2'd0,
        KIND_STEP   = 2'd1,
        KIND_TICK   = 2'd2
    } t_kind;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_BAD_ID = 2'd1;
    localparam logic [1:0] STATUS_BUSY   = 2'd2;

    localparam logic [2:0] CFG_STEPS_REV0 = 3'd0;
    localparam logic [2:0] CFG_STEPS_REV1 = 3'd1;
    localparam logic [2:0] CFG_STEPS_REV2 = 3'd2;
    localparam logic [2:0] CFG_STEPS_REV3 = 3'd3;
    localparam logic [2:0] CFG_POLARITY   = 3'd4;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] motor_id;
        logic [7:0] amount;
        logic       clockwise;
        logic [7:0] phase_ticks;
    } t_in_word;

    typedef struct packed {
        logic [3:0] coil_pattern;
        logic [1:0] driven_motor;
        logic [1:0] status;
        logic       running;
        logic       move_done;
    } t_out_word;

    typedef struct packed {
        logic [3:0][12:0] steps_rev;
        logic [3:0]       polarity;
    } t_cfg_state;

    // One-hot coil pattern, one-cold when the motor's polarity bit is set.
    function automatic logic [3:0] form_pattern(input logic [1:0] motor,
                                                input logic       dir,
                                                input logic [1:0] phase,
                                                input logic [3:0] polarity);
        logic [3:0] hot;
        hot = dir ? (4'b0001 << phase) : (4'b1000 >> phase);
        if (polarity[motor]) begin
            hot = ~hot;
        end
        return hot;
    endfunction

endpackage

// File: hdl/swds_cfg_regs.sv
// ---------------------------------------------------------------------------
// swds_cfg_regs - configuration registers
// Steps per revolution for each motor and the polarity mask.
// ---------------------------------------------------------------------------
module swds_cfg_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [12:0]           i_cfg_data,
    output swds_pkg::t_cfg_state  o_cfg
);
    import swds_pkg::*;

    t_cfg_state r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps_rev <= {4{STEPS_REV_RESET}};
            r_cfg.polarity  <= 4'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STEPS_REV0: r_cfg.steps_rev[0] <= i_cfg_data;
                CFG_STEPS_REV1: r_cfg.steps_rev[1] <= i_cfg_data;
                CFG_STEPS_REV2: r_cfg.steps_rev[2] <= i_cfg_data;
                CFG_STEPS_REV3: r_cfg.steps_rev[3] <= i_cfg_data;
                CFG_POLARITY:   r_cfg.polarity     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

endmodule

// File: hdl/swds_scale_stage.sv
// ---------------------------------------------------------------------------
// swds_scale_stage - input register and angle product
// Registers the command word, then forms angle times steps-per-rev and
// registers it with the word for the sequencer core.
// ---------------------------------------------------------------------------
module swds_scale_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  swds_pkg::t_in_word    i_in_word,
    output logic                  o_in_stall,
    input  swds_pkg::t_cfg_state  i_cfg,
    input  logic                  i_take,
    output logic                  o_b_valid,
    output swds_pkg::t_in_word    o_b_word,
    output logic [19:0]           o_b_prod
);
    import swds_pkg::*;

    logic        r_a_valid;
    t_in_word    r_a_word;
    logic        r_b_valid;
    t_in_word    r_b_word;
    logic [19:0] r_b_prod;

    logic        a_adv;
    logic        b_adv;
    logic [12:0] sr_raw;
    logic [12:0] sr_sat;
    logic [20:0] prod_full;
    logic [19:0] n_prod;

    assign b_adv      = !r_b_valid || i_take;
    assign a_adv      = !r_a_valid || b_adv;
    assign o_in_stall = !a_adv;

    always_comb begin
        sr_raw    = i_cfg.steps_rev[r_a_word.motor_id[1:0]];
        sr_sat    = (sr_raw > STEPS_REV_MAX) ? STEPS_REV_MAX : sr_raw;
        prod_full = 21'(r_a_word.amount) * 21'(sr_sat);
        n_prod    = prod_full[19:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_adv) begin
                r_a_valid <= i_in_valid;
            end
            if (b_adv) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && i_in_valid) begin
            r_a_word <= i_in_word;
        end
        if (b_adv && r_a_valid) begin
            r_b_word <= r_a_word;
            r_b_prod <= n_prod;
        end
    end

    assign o_b_valid = r_b_valid;
    assign o_b_word  = r_b_word;
    assign o_b_prod  = r_b_prod;

endmodule

// File: hdl/swds_seq_core.sv
// ---------------------------------------------------------------------------
// swds_seq_core - move state and result register
// Finishes the divide by 360, runs the command and tick logic of the
// move, keeps the last pattern of each motor and registers the result.
// ---------------------------------------------------------------------------
module swds_seq_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_b_valid,
    input  swds_pkg::t_in_word    i_b_word,
    input  logic [19:0]           i_b_prod,
    input  swds_pkg::t_cfg_state  i_cfg,
    output logic                  o_take,
    output logic                  o_out_valid,
    output swds_pkg::t_out_word   o_out_word,
    input  logic                  i_out_stall
);
    import swds_pkg::*;

    logic             r_busy;
    logic [1:0]       r_motor;
    logic             r_dir;
    logic [1:0]       r_phase;
    logic [13:0]      r_phases_left;
    logic [7:0]       r_hold_reload;
    logic [7:0]       r_hold_count;
    logic [3:0][3:0]  r_pattern;
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic             n_busy;
    logic [1:0]       n_motor;
    logic             n_dir;
    logic [1:0]       n_phase;
    logic [13:0]      n_phases_left;
    logic [7:0]       n_hold_reload;
    logic [7:0]       n_hold_count;
    logic [3:0][3:0]  n_pattern;
    t_out_word        n_out_word;

    logic             out_adv;
    logic [34:0]      quot_full;
    logic [11:0]      rot_steps;
    logic [11:0]      steps;
    logic [1:0]       status;
    logic             done;

    assign out_adv = !r_out_valid || !i_out_stall;
    assign o_take  = i_b_valid && out_adv;

    always_comb begin
        quot_full = 35'(i_b_prod[19:DIV_PRE_SHIFT]) * 35'(DIV_RECIP);
        rot_steps = 12'(quot_full >> DIV_SHIFT);
        steps     = (i_b_word.kind == KIND_ROTATE) ? rot_steps
                                                   : {4'd0, i_b_word.amount};
    end

    always_comb begin
        n_busy        = r_busy;
        n_motor       = r_motor;
        n_dir         = r_dir;
        n_phase       = r_phase;
        n_phases_left = r_phases_left;
        n_hold_reload = r_hold_reload;
        n_hold_count  = r_hold_count;
        n_pattern     = r_pattern;
        status        = STATUS_OK;
        done          = 1'b0;
        case (i_b_word.kind)
            KIND_ROTATE, KIND_STEP: begin
                if (i_b_word.motor_id >= MOTOR_LIMIT) begin
                    status = STATUS_BAD_ID;
                end else if (r_busy) begin
                    status = STATUS_BUSY;
                end else if (steps != 12'd0) begin
                    n_busy        = 1'b1;
                    n_motor       = i_b_word.motor_id[1:0];
                    n_dir         = i_b_word.clockwise;
                    n_phase       = 2'd0;
                    n_phases_left = {steps, 2'b00};
                    n_hold_reload = (i_b_word.phase_ticks == 8'd0) ? 8'd1
                                                                   : i_b_word.phase_ticks;
                    n_hold_count  = n_hold_reload;
                    n_pattern[n_motor] = form_pattern(n_motor, n_dir, n_phase,
                                                      i_cfg.polarity);
                end
            end
            KIND_TICK: begin
                if (r_busy) begin
                    if (r_hold_count != 8'd0) begin
                        n_hold_count = r_hold_count - 8'd1;
                    end
                    if (n_hold_count == 8'd0) begin
                        if (r_phases_left != 14'd0) begin
                            n_phases_left = r_phases_left - 14'd1;
                        end
                        if (n_phases_left == 14'd0) begin
                            // end of move: last phase stays energised
                            n_busy = 1'b0;
                            done   = 1'b1;
                        end else begin
                            n_phase      = r_phase + 2'd1;
                            n_hold_count = r_hold_reload;
                            n_pattern[r_motor] = form_pattern(r_motor, r_dir, n_phase,
                                                              i_cfg.polarity);
                        end
                    end
                end
            end
            default: ;
        endcase
        n_out_word.coil_pattern = n_pattern[n_motor];
        n_out_word.driven_motor = n_motor;
        n_out_word.status       = status;
        n_out_word.running      = n_busy;
        n_out_word.move_done    = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_motor       <= 2'd0;
            r_dir         <= 1'b0;
            r_phase       <= 2'd0;
            r_phases_left <= 14'd0;
            r_hold_reload <= 8'd0;
            r_hold_count  <= 8'd0;
            r_pattern     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_take) begin
                r_busy        <= n_busy;
                r_motor       <= n_motor;
                r_dir         <= n_dir;
                r_phase       <= n_phase;
                r_phases_left <= n_phases_left;
                r_hold_reload <= n_hold_reload;
                r_hold_count  <= n_hold_count;
                r_pattern     <= n_pattern;
            end
            if (out_adv) begin
                r_out_valid <= i_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: hdl/stepper_wave_drive_sequencer_unit.sv
// ---------------------------------------------------------------------------
// stepper_wave_drive_sequencer_unit - wave-drive sequencer for four steppers
// Takes rotate, step and tick command words and returns one status and
// coil pattern word for each.
// ---------------------------------------------------------------------------
//  channel  | signals                          | moves
//  ---------+----------------------------------+------------------------------
//  in       | i_in_valid, o_in_stall, i_in_word   | one command or tick word
//  out      | o_out_valid, i_out_stall, o_out_word| one result word
//  cfg      | i_cfg_valid, o_cfg_ready, index/data| one register write
//
//  One word per cycle sustained while the output does not stall; each word
//  passes the input register, the product register (angle times
//  steps-per-rev), then the divide, move update and result register.
//  Synchronous active-low reset clears all move state and coil patterns.
//  A stalled output holds its word; the pipeline behind it keeps filling
//  its empty stages before o_in_stall rises.
// ---------------------------------------------------------------------------
module stepper_wave_drive_sequencer_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  swds_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output swds_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [12:0]          i_cfg_data
);
    import swds_pkg::*;

    t_cfg_state  cfg;
    logic        take;
    logic        b_valid;
    t_in_word    b_word;
    logic [19:0] b_prod;

    swds_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    swds_scale_stage u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_cfg      (cfg),
        .i_take     (take),
        .o_b_valid  (b_valid),
        .o_b_word   (b_word),
        .o_b_prod   (b_prod)
    );

    swds_seq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_b_valid   (b_valid),
        .i_b_word    (b_word),
        .i_b_prod    (b_prod),
        .i_cfg       (cfg),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: sim/swds_drive_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// swds_drive_checker - result checker for the stepper wave-drive sequencer
// Watches the command, result and register channels, keeps its own model of
// the move state and coil lines, queues the result word each command word
// should give and compares every returned word field by field.
// ---------------------------------------------------------------------------
module swds_drive_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  swds_pkg::t_in_word   i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  swds_pkg::t_out_word  i_out_word,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [12:0]          i_cfg_data,
    output int                   o_fail_count
);
    import swds_pkg::*;

    logic [12:0] rev_per_motor [4];
    logic [3:0]  invert_mask;

    logic        moving;
    logic [1:0]  motor_on;
    logic        turn_cw;
    logic [1:0]  phase_at;
    logic [13:0] phases_due;
    logic [7:0]  hold_len;
    logic [7:0]  hold_left;
    logic [3:0]  coils_shown [4];

    t_out_word   words_due [$];
    int          mismatches = 0;

    // Lit coil for a phase: clockwise walks yellow to pink, otherwise back.
    function automatic logic [3:0] coil_drive(input logic [1:0] motor,
                                              input logic       cw,
                                              input logic [1:0] phase);
        logic [1:0] lit;
        logic [3:0] lines;
        lit   = cw ? phase : ~phase;
        lines = 4'b0001 << lit;
        if (invert_mask[motor]) begin
            lines = ~lines;
        end
        return lines;
    endfunction

    task automatic advance_drive(input t_in_word w, output t_out_word r);
        logic [31:0] rev_eff;
        logic [31:0] steps;
        logic [1:0]  stat;
        logic        finished;
        stat     = STATUS_OK;
        finished = 1'b0;
        if (w.kind == KIND_ROTATE || w.kind == KIND_STEP) begin
            if (w.motor_id >= MOTOR_LIMIT) begin
                stat = STATUS_BAD_ID;
            end else if (moving) begin
                stat = STATUS_BUSY;
            end else begin
                if (w.kind == KIND_ROTATE) begin
                    rev_eff = 32'(rev_per_motor[w.motor_id[1:0]]);
                    if (rev_eff > 32'(STEPS_REV_MAX)) begin
                        rev_eff = 32'(STEPS_REV_MAX);
                    end
                    steps = (32'(w.amount) * rev_eff) / 32'(DEGREES_PER_REV);
                end else begin
                    steps = 32'(w.amount);
                end
                if (steps != 0) begin
                    moving     = 1'b1;
                    motor_on   = w.motor_id[1:0];
                    turn_cw    = w.clockwise;
                    phase_at   = 2'd0;
                    phases_due = 14'(steps * 4);
                    hold_len   = (w.phase_ticks == 8'd0) ? 8'd1 : w.phase_ticks;
                    hold_left  = hold_len;
                    coils_shown[motor_on] = coil_drive(motor_on, turn_cw, phase_at);
                end
            end
        end else if (w.kind == KIND_TICK && moving) begin
            if (hold_left != 0) begin
                hold_left--;
            end
            if (hold_left == 0) begin
                if (phases_due != 0) begin
                    phases_due--;
                end
                if (phases_due == 0) begin
                    // last phase stays energised
                    moving   = 1'b0;
                    finished = 1'b1;
                end else begin
                    phase_at++;
                    hold_left = hold_len;
                    coils_shown[motor_on] = coil_drive(motor_on, turn_cw, phase_at);
                end
            end
        end
        r.coil_pattern = coils_shown[motor_on];
        r.driven_motor = motor_on;
        r.status       = stat;
        r.running      = moving;
        r.move_done    = finished;
    endtask

    always @(posedge i_clk) begin
        t_out_word due;
        t_out_word got;
        if (!i_rst_n) begin
            for (int m = 0; m < 4; m++) begin
                rev_per_motor[m] = STEPS_REV_RESET;
                coils_shown[m]   = 4'd0;
            end
            invert_mask = 4'd0;
            moving      = 1'b0;
            motor_on    = 2'd0;
            turn_cw     = 1'b0;
            phase_at    = 2'd0;
            phases_due  = 14'd0;
            hold_len    = 8'd0;
            hold_left   = 8'd0;
            words_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_POLARITY) begin
                    invert_mask = i_cfg_data[3:0];
                end else if (i_cfg_index <= CFG_STEPS_REV3) begin
                    rev_per_motor[i_cfg_index[1:0]] = i_cfg_data;
                end
            end
            // compare before queueing so a word taken this edge is never matched early
            if (i_out_valid && !i_out_stall) begin
                got = i_out_word;
                if (words_due.size() == 0) begin
                    $error("result word %h arrived with none expected", got);
                    mismatches++;
                end else begin
                    due = words_due.pop_front();
                    if (got.coil_pattern != due.coil_pattern) begin
                        $error("coil_pattern: expected %0h, got %0h",
                               due.coil_pattern, got.coil_pattern);
                        mismatches++;
                    end
                    if (got.driven_motor != due.driven_motor) begin
                        $error("driven_motor: expected %0d, got %0d",
                               due.driven_motor, got.driven_motor);
                        mismatches++;
                    end
                    if (got.status != due.status) begin
                        $error("status: expected %0d, got %0d", due.status, got.status);
                        mismatches++;
                    end
                    if (got.running != due.running) begin
                        $error("running: expected %0d, got %0d", due.running, got.running);
                        mismatches++;
                    end
                    if (got.move_done != due.move_done) begin
                        $error("move_done: expected %0d, got %0d",
                               due.move_done, got.move_done);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_drive(i_in_word, due);
                words_due.push_back(due);
            end
        end
        // anything still queued counts against the run
        o_fail_count = mismatches + words_due.size();
    end

endmodule

// File: sim/tb_stepper_wave_drive_sequencer_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_stepper_wave_drive_sequencer_unit - testbench for the wave-drive sequencer
// Directed words for bad ids, zero steps, idle and ignored words, a wide
// rotate and every register extreme, then random moves with stray and busy
// words cutting in, under random gaps and stalls on both channels and one
// long output hold-off. Checking is done by swds_drive_checker.
// ---------------------------------------------------------------------------
module tb_stepper_wave_drive_sequencer_unit;
    import swds_pkg::*;

    localparam int         CYCLE_LIMIT  = 400_000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         RANDOM_WORDS = 1000;
    localparam int         RETUNE_EVERY = 400;
    localparam int         LONG_HOLD_AT = 700;
    localparam int         LONG_HOLD    = 400;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_word    in_word;
    logic        out_valid;
    logic        out_stall;
    t_out_word   out_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;
    int          fail_count;

    int          words_sent  = 0;
    int          words_taken = 0;
    int          cycle_count = 0;
    bit          quiet_mode  = 1'b0;
    logic [12:0] rev_copy [4];

    stepper_wave_drive_sequencer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    swds_drive_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random hold after each word, one long hold to back up the pipe.
    initial begin : result_sink
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_valid && !out_stall) begin
                words_taken++;
                hold = quiet_mode ? 0 : $urandom_range(0, 6);
                if (words_taken == LONG_HOLD_AT) begin
                    hold = LONG_HOLD;
                end
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                hold--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic t_in_word random_word();
        logic [31:0] raw;
        raw = $urandom;
        return raw[$bits(t_in_word)-1:0];
    endfunction

    function automatic t_in_word cmd_word(input logic [1:0] kind, input logic [2:0] motor,
                                          input logic [7:0] amount, input logic cw,
                                          input logic [7:0] ticks);
        t_in_word w;
        w.kind        = kind;
        w.motor_id    = motor;
        w.amount      = amount;
        w.clockwise   = cw;
        w.phase_ticks = ticks;
        return w;
    endfunction

    function automatic t_in_word tick_word();
        t_in_word w;
        w      = random_word();
        w.kind = KIND_TICK;
        return w;
    endfunction

    function automatic logic [31:0] rev_limited(input logic [1:0] motor);
        return (rev_copy[motor] > STEPS_REV_MAX) ? 32'(STEPS_REV_MAX) : 32'(rev_copy[motor]);
    endfunction

    // Ticks a command from idle keeps the motor busy for.
    function automatic int move_ticks(input t_in_word w);
        logic [31:0] steps;
        if (w.kind == KIND_STEP) begin
            steps = 32'(w.amount);
        end else begin
            steps = 32'(w.amount) * rev_limited(w.motor_id[1:0]) / 32'(DEGREES_PER_REV);
        end
        return int'(steps) * 4 * ((w.phase_ticks == 8'd0) ? 1 : int'(w.phase_ticks));
    endfunction

    // A word that must not start a move: bad id, ignored kind, or a command
    // that is refused as busy (or has zero steps when idle).
    function automatic t_in_word stray_word(input bit busy);
        t_in_word w;
        w = random_word();
        case ($urandom_range(0, 2))
            0: begin
                w.kind     = $urandom_range(0, 1) ? KIND_STEP : KIND_ROTATE;
                w.motor_id = 3'($urandom_range(MOTOR_COUNT, 7));
            end
            1: begin
                w.kind = KIND_IGNORED;
            end
            default: begin
                w.kind     = $urandom_range(0, 1) ? KIND_STEP : KIND_ROTATE;
                w.motor_id = 3'($urandom_range(0, MOTOR_COUNT - 1));
                if (!busy) begin
                    w.amount = 8'd0;
                end
            end
        endcase
        return w;
    endfunction

    // Short moves keep the random part from stalling on one long move.
    function automatic t_in_word move_word();
        t_in_word w;
        int       amax;
        w             = random_word();
        w.motor_id    = 3'($urandom_range(0, MOTOR_COUNT - 1));
        w.phase_ticks = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) begin
            w.kind   = KIND_STEP;
            w.amount = 8'($urandom_range(1, 6));
            if ($urandom_range(1, 40) == 1) begin
                w.amount      = 8'd1;
                w.phase_ticks = 8'($urandom_range(4, 64));
            end
        end else begin
            w.kind = KIND_ROTATE;
            amax   = 255;
            if (rev_limited(w.motor_id[1:0]) != 0) begin
                amax = 2160 / int'(rev_limited(w.motor_id[1:0]));
            end
            amax     = (amax < 1) ? 1 : ((amax > 255) ? 255 : amax);
            w.amount = 8'($urandom_range(0, amax));
        end
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!(in_valid && !in_stall)) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    // Command, then exactly the ticks that finish it, strays cutting in at random.
    task automatic drive_move(input t_in_word cmd, input int cut_in_pct);
        int left;
        left = move_ticks(cmd);
        send_word(cmd);
        while (left > 0) begin
            if ($urandom_range(1, 100) <= cut_in_pct) begin
                send_word(stray_word(1'b1));
            end else begin
                send_word(tick_word());
                left--;
            end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (words_taken != words_sent) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!(cfg_valid && cfg_ready)) begin
            @(posedge i_clk);
        end
        if (idx != CFG_POLARITY) begin
            rev_copy[idx[1:0]] = data;
        end
    endtask

    function automatic logic [12:0] pick_rev();
        case ($urandom_range(0, 7))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return STEPS_REV_MAX;
            3:       return STEPS_REV_MAX + 13'd1;
            4:       return '1;
            5:       return STEPS_REV_RESET;
            default: return 13'($urandom_range(1, 4096));
        endcase
    endfunction

    task automatic retune_registers();
        logic [2:0] idx;
        repeat ($urandom_range(1, 3)) begin
            idx = 3'($urandom_range(CFG_STEPS_REV0, CFG_POLARITY));
            if (idx == CFG_POLARITY) begin
                write_reg(idx, 13'($urandom));
            end else begin
                write_reg(idx, pick_rev());
            end
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int base;
        int epoch;
        int pick;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STEPS_REV0;
        cfg_data  = '0;
        for (int m = 0; m < 4; m++) begin
            rev_copy[m] = STEPS_REV_RESET;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle tick and ignored kind with every field bit high, then bad ids
        send_word(cmd_word(KIND_TICK, '1, '1, 1'b1, '1));
        send_word('1);
        send_word(cmd_word(KIND_STEP, '1, '1, 1'b1, '1));
        send_word(cmd_word(KIND_ROTATE, MOTOR_LIMIT, 8'd0, 1'b0, 8'd0));
        // zero steps: angle rounding to nothing, and a zero count
        send_word(cmd_word(KIND_ROTATE, 3'd0, 8'd1, 1'b1, 8'd5));
        send_word(cmd_word(KIND_STEP, 3'd3, 8'd0, 1'b0, 8'd5));
        // one step, then refused while busy, bad id while busy, then finish
        send_word(cmd_word(KIND_STEP, 3'd0, 8'd1, 1'b1, 8'd0));
        send_word(cmd_word(KIND_STEP, 3'd1, 8'd5, 1'b0, 8'd2));
        send_word(cmd_word(KIND_ROTATE, 3'd5, 8'd90, 1'b1, 8'd1));
        repeat (4) send_word(tick_word());
        // wide rotate
        drive_move(cmd_word(KIND_ROTATE, 3'd1, 8'd255, 1'b1, 8'd0), 2);

        wait_idle();
        write_reg(CFG_STEPS_REV0, 13'd1);
        write_reg(CFG_STEPS_REV1, STEPS_REV_MAX);
        write_reg(CFG_STEPS_REV2, '1);
        write_reg(CFG_STEPS_REV3, 13'd0);
        write_reg(CFG_POLARITY, 13'h1FFA);
        cfg_valid <= 1'b0;

        send_word(cmd_word(KIND_ROTATE, 3'd0, 8'd255, 1'b1, 8'd1));
        drive_move(cmd_word(KIND_ROTATE, 3'd1, 8'd1, 1'b0, 8'd1), 0);
        drive_move(cmd_word(KIND_ROTATE, 3'd2, 8'd1, 1'b1, 8'd2), 0);
        send_word(cmd_word(KIND_ROTATE, 3'd3, 8'd255, 1'b0, 8'd1));
        drive_move(cmd_word(KIND_STEP, 3'd3, 8'd2, 1'b0, 8'd3), 20);
        drive_move(cmd_word(KIND_STEP, 3'd1, 8'd3, 1'b1, 8'd0), 0);

        wait_idle();
        write_reg(CFG_STEPS_REV1, STEPS_REV_MAX + 13'd1);
        write_reg(CFG_POLARITY, 13'h0005);
        cfg_valid <= 1'b0;

        base  = words_sent;
        epoch = 0;
        while (words_sent - base < RANDOM_WORDS) begin
            if ((words_sent - base) / RETUNE_EVERY != epoch) begin
                epoch = (words_sent - base) / RETUNE_EVERY;
                wait_idle();
                retune_registers();
            end
            quiet_mode = ($urandom_range(1, 10) == 1);
            pick       = $urandom_range(1, 100);
            if (pick <= 75) begin
                drive_move(move_word(), 10);
            end else if (pick <= 90) begin
                send_word(stray_word(1'b0));
            end else begin
                send_word(tick_word());
            end
        end
        quiet_mode = 1'b0;

        wait_idle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
